// File: src/pcpa_pkg.sv
package pcpa_pkg;

  localparam int NUM_CPUS_DEF   = 8;
  localparam int PAGE_SLOTS_DEF = 32768;

  // Page size is fixed; a page is a power of two bytes
  localparam int PAGE_BYTES = 4096;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

  localparam logic [31:0] CFG_FIRST_RESET = 32'h8000_0000;
  localparam logic [31:0] CFG_TOP_RESET   = 32'h8800_0000;

  // Widest processor index over the supported range of NUM_CPUS
  localparam int CPU_MAX_W = 4;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_OOM    = 2'd1,
    ST_REJECT = 2'd2
  } status_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic {
    CFG_FIRST_FREE = 1'b0,
    CFG_TOP        = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FREE,
    S_POP
  } state_t;

  typedef struct packed {
    logic                 found;
    logic [CPU_MAX_W-1:0] donor;
  } pick_t;

endpackage

// File: src/pcpa_link_mem.sv
module pcpa_link_mem
  import pcpa_pkg::*;
#(
  parameter int DEPTH = PAGE_SLOTS_DEF,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/pcpa_donor_pick.sv
module pcpa_donor_pick
  import pcpa_pkg::*;
#(
  parameter int NUM_CPUS = NUM_CPUS_DEF
) (
  input  logic [NUM_CPUS-1:0]  head_valid,
  input  logic [CPU_MAX_W-1:0] start,
  output pick_t                pick
);

  logic [(1 << CPU_MAX_W)-1:0] valid_ext;

  assign valid_ext = (1 << CPU_MAX_W)'(head_valid);

  // Walk from the far end back so the nearest list at or after start wins
  always_comb begin
    logic [CPU_MAX_W:0] idx;
    pick = '0;
    for (int k = NUM_CPUS - 1; k >= 0; k--) begin
      idx = {1'b0, start} + (CPU_MAX_W + 1)'(k);
      if (idx >= (CPU_MAX_W + 1)'(NUM_CPUS)) begin
        idx = idx - (CPU_MAX_W + 1)'(NUM_CPUS);
      end
      if (valid_ext[idx[CPU_MAX_W-1:0]]) begin
        pick.found = 1'b1;
        pick.donor = idx[CPU_MAX_W-1:0];
      end
    end
  end

endmodule

// File: src/per_cpu_page_free_list_allocator.sv
// Per-processor page allocator: one LIFO free list per processor, chained
// through a link memory with one entry per page slot.
// Input channel (in_valid/in_stall) carries command, cpu and address; the
// output channel (out_valid/out_stall) returns page_addr, status and
// source_cpu, one result beat per input beat, in order.
// A free pushes the page onto the requesting processor's list, or is
// rejected (status 2) when unaligned, outside first_free_addr..top_addr or
// past the last page slot. An allocate pops the requester's list, else
// steals from the next non-empty list in rising circular order; status 1
// when all are empty. One item is in flight at a time: the S_FREE or S_POP
// state registers its result, waiting while the output register is full,
// and no beat is taken before that; a waiting result does not stop the next
// beat being taken. Reset empties every list and restores both address
// registers. The link memory needs no clearing: an entry is written when its
// page is pushed. Configuration is written through cfg_write/cfg_index/
// cfg_data, and only while idle: the user must keep to this, as the block
// itself does not enforce it.
module per_cpu_page_free_list_allocator
  import pcpa_pkg::*;
#(
  parameter int NUM_CPUS   = NUM_CPUS_DEF,
  parameter int PAGE_SLOTS = PAGE_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [2:0]  cpu,
  input  logic [31:0] address,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] page_addr,
  output logic [1:0]  status,
  output logic [2:0]  source_cpu
);

  localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int SLOT_W = $clog2(PAGE_SLOTS);
  localparam int LINK_W = SLOT_W + 1;
  localparam int PNUM_W = 32 - PAGE_SHIFT;

  // Configuration registers and derived page base
  logic [31:0]     first_free_addr;
  logic [31:0]     top_addr;
  logic [32:0]     base;

  logic [SLOT_W-1:0] heads [NUM_CPUS];
  logic [NUM_CPUS-1:0] head_valid;

  state_t state, state_next;

  // Item held while in flight
  logic [CPU_W-1:0]  item_cpu;
  logic [31:0]       item_addr;
  logic              pop_found;
  logic [CPU_W-1:0]  pop_donor;
  logic [SLOT_W-1:0] pop_slot;

  logic              accept;
  logic              out_free;
  logic              finish;

  logic [CPU_MAX_W-1:0] cpu_mod;
  pick_t                pick;
  logic [CPU_W-1:0]     pick_donor;

  logic              mem_we;
  logic              mem_re;
  logic [LINK_W-1:0] mem_wdata;
  logic [LINK_W-1:0] mem_rdata;

  logic              free_ok;
  logic [31:0]       page_off;
  logic [PNUM_W-1:0] page_num;
  logic [SLOT_W-1:0] free_slot;
  logic [31:0]       alloc_addr;
  logic [CPU_W+2:0]  donor_ext;

  // cpu modulo NUM_CPUS by repeated subtraction on a narrow value
  always_comb begin
    logic [CPU_MAX_W:0] r;
    r = (CPU_MAX_W + 1)'(cpu);
    for (int i = 0; i < 8; i++) begin
      if (r >= (CPU_MAX_W + 1)'(NUM_CPUS)) begin
        r = r - (CPU_MAX_W + 1)'(NUM_CPUS);
      end
    end
    cpu_mod = r[CPU_MAX_W-1:0];
  end

  pcpa_donor_pick #(
    .NUM_CPUS (NUM_CPUS)
  ) u_pick (
    .head_valid (head_valid),
    .start      (cpu_mod),
    .pick       (pick)
  );

  assign pick_donor = pick.donor[CPU_W-1:0];

  pcpa_link_mem #(
    .DEPTH (PAGE_SLOTS),
    .WIDTH (LINK_W)
  ) u_links (
    .clk   (clk),
    .we    (mem_we),
    .waddr (free_slot),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (heads[pick_donor]),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      first_free_addr <= CFG_FIRST_RESET;
      top_addr        <= CFG_TOP_RESET;
    end else if (cfg_write) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FIRST_FREE: first_free_addr <= cfg_data;
        CFG_TOP:        top_addr        <= cfg_data;
        default:        ;
      endcase
    end
  end

  // Round first_free_addr up to a page; may reach 2^32
  always_ff @(posedge clk) begin
    base <= ({1'b0, first_free_addr} + 33'(PAGE_BYTES - 1))
            & ~33'(PAGE_BYTES - 1);
  end

  // Free checks and slot number
  assign page_off  = item_addr - base[31:0];
  assign page_num  = page_off[31:PAGE_SHIFT];
  assign free_slot = page_num[SLOT_W-1:0];
  assign free_ok   = (item_addr[PAGE_SHIFT-1:0] == '0)
                  && (item_addr >= first_free_addr)
                  && (item_addr < top_addr)
                  && (32'(page_num) < 32'(PAGE_SLOTS));
  assign mem_wdata = {head_valid[item_cpu], heads[item_cpu]};

  assign alloc_addr = base[31:0] + (32'(pop_slot) << PAGE_SHIFT);
  assign donor_ext  = (CPU_W + 3)'(pop_donor);

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    accept     = 1'b0;
    finish     = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        accept   = in_valid;
        if (in_valid) begin
          if (cmd_t'(command) == CMD_FREE) begin
            state_next = S_FREE;
          end else begin
            mem_re     = pick.found;
            state_next = S_POP;
          end
        end
      end
      S_FREE: begin
        if (out_free) begin
          finish     = 1'b1;
          mem_we     = free_ok;
          state_next = S_IDLE;
        end
      end
      S_POP: begin
        if (out_free) begin
          finish     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Latch the beat; for allocate, also the chosen donor and its head
  always_ff @(posedge clk) begin
    if (accept) begin
      item_cpu  <= cpu_mod[CPU_W-1:0];
      item_addr <= address;
      pop_found <= pick.found;
      pop_donor <= pick_donor;
      pop_slot  <= heads[pick_donor];
    end
  end

  // List heads: push on a good free, advance on a pop
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= '0;
    end else if (finish) begin
      if (state == S_FREE && free_ok) begin
        head_valid[item_cpu] <= 1'b1;
      end else if (state == S_POP && pop_found) begin
        head_valid[pop_donor] <= mem_rdata[SLOT_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      if (state == S_FREE && free_ok) begin
        heads[item_cpu] <= free_slot;
      end else if (state == S_POP && pop_found) begin
        heads[pop_donor] <= mem_rdata[SLOT_W-1:0];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      page_addr  <= '0;
      source_cpu <= '0;
      status     <= ST_OK;
      if (state == S_FREE) begin
        if (!free_ok) begin
          status <= ST_REJECT;
        end
      end else if (pop_found) begin
        page_addr  <= alloc_addr;
        source_cpu <= donor_ext[2:0];
      end else begin
        status <= ST_OOM;
      end
    end
  end

endmodule

// File: tb/per_cpu_page_free_list_allocator_tb.sv
module per_cpu_page_free_list_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pcpa_pkg::*;

  localparam int CPUS  = NUM_CPUS_DEF;
  localparam int SLOTS = PAGE_SLOTS_DEF;
  localparam int unsigned CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic [31:0] page_addr;
    status_t     status;
    logic [2:0]  source_cpu;
  } page_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        command = 1'b0;
  logic [2:0]  cpu = '0;
  logic [31:0] address = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] page_addr;
  logic [1:0]  status;
  logic [2:0]  source_cpu;

  per_cpu_page_free_list_allocator dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .cpu        (cpu),
    .address    (address),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .page_addr  (page_addr),
    .status     (status),
    .source_cpu (source_cpu)
  );

  always #2 clk = ~clk;

  // Shadow of the allocator: registers, list heads and link memory
  logic [31:0] first_free = CFG_FIRST_RESET;
  logic [31:0] top_lim    = CFG_TOP_RESET;
  logic [15:0] head_slot [CPUS];
  logic        head_live [CPUS];
  logic [15:0] link_slot [SLOTS];
  logic        link_live [SLOTS];

  page_result_t pending_results[$];
  int unsigned  fail_count = 0;
  int unsigned  cycle_count = 0;
  bit           send_gaps = 1'b1;
  bit           recv_gaps = 1'b1;
  int unsigned  recv_hold = 0;

  function automatic longint unsigned page_base();
    longint unsigned f;
    f = first_free;
    return ((f + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;
  endfunction

  function automatic page_result_t predict_page_op(cmd_t cmd, logic [2:0] c, logic [31:0] a);
    page_result_t    r;
    longint unsigned base, slot, sum;
    int unsigned     who, donor;
    logic [15:0]     s;
    bit              found;
    r = '{page_addr: '0, status: ST_OK, source_cpu: '0};
    base = page_base();
    who = c % CPUS;
    found = 1'b0;
    if (cmd == CMD_FREE) begin
      if ((a % PAGE_BYTES) != 0 || a < first_free || a >= top_lim) begin
        r.status = ST_REJECT;
      end else begin
        slot = ({32'b0, a} - base) / PAGE_BYTES;
        if (slot >= SLOTS) begin
          r.status = ST_REJECT;
        end else begin
          link_slot[slot] = head_slot[who];
          link_live[slot] = head_live[who];
          head_slot[who] = slot[15:0];
          head_live[who] = 1'b1;
        end
      end
    end else begin
      // Own list first, then steal in rising circular order
      for (int k = 0; k < CPUS; k++) begin
        donor = (who + k) % CPUS;
        if (!found && head_live[donor]) begin
          found = 1'b1;
          s = 16'(head_slot[donor] % SLOTS);
          head_slot[donor] = link_slot[s];
          head_live[donor] = link_live[s];
          sum = base + longint'(s) * PAGE_BYTES;
          r.page_addr = sum[31:0];
          r.source_cpu = donor[2:0];
        end
      end
      if (!found) r.status = ST_OOM;
    end
    return r;
  endfunction

  function automatic logic [31:0] page_in_window(int unsigned span);
    longint unsigned sum;
    sum = page_base() + longint'($urandom_range(0, span - 1)) * PAGE_BYTES;
    return sum[31:0];
  endfunction

  // Slots around the capacity limit and well beyond it
  function automatic logic [31:0] page_near_capacity();
    longint unsigned slot, sum;
    case ($urandom_range(0, 3))
      0: slot = SLOTS - 1;
      1: slot = SLOTS;
      2: slot = $urandom_range(SLOTS - 4, SLOTS + 4);
      default: slot = $urandom_range(0, 2 * SLOTS);
    endcase
    sum = page_base() + slot * PAGE_BYTES;
    return sum[31:0];
  endfunction

  // Entered and left at a falling edge
  task automatic send_item(cmd_t cmd, logic [2:0] c, logic [31:0] a);
    int unsigned gap;
    gap = send_gaps ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    cpu      <= c;
    address  <= a;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_page_op(cmd, c, a));
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == CFG_FIRST_FREE) first_free = val;
    else top_lim = val;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_random_traffic(int unsigned items, int unsigned span,
                                    int unsigned free_pct, int unsigned far_pct);
    int unsigned pick;
    logic [2:0]  c;
    for (int unsigned i = 0; i < items; i++) begin
      pick = $urandom_range(0, 99);
      c = 3'($urandom_range(0, 7));
      if (pick < 3) begin
        send_item(cmd_t'($urandom_range(0, 1)), c, $urandom());
      end else if (pick < 6) begin
        // Misaligned page: valid window address with low bits set
        send_item(CMD_FREE, c, page_in_window(span) | $urandom_range(1, PAGE_BYTES - 1));
      end else if (pick < 6 + far_pct) begin
        send_item(CMD_FREE, c, page_near_capacity());
      end else if (pick < free_pct) begin
        send_item(CMD_FREE, c, page_in_window(span));
      end else begin
        send_item(CMD_ALLOC, c, $urandom());
      end
    end
  endtask

  task automatic test_directed_basics();
    send_item(CMD_ALLOC, 3'd0, 32'h0000_0000);
    send_item(CMD_FREE,  3'd0, 32'h8000_0000);
    send_item(CMD_FREE,  3'd7, 32'h87FF_F000);
    send_item(CMD_FREE,  3'd3, 32'h8800_0000);
    send_item(CMD_FREE,  3'd3, 32'h7FFF_F000);
    send_item(CMD_FREE,  3'd3, 32'h8000_0800);
    send_item(CMD_FREE,  3'd7, 32'hFFFF_FFFF);
    send_item(CMD_FREE,  3'd0, 32'h0000_0000);
    send_item(CMD_ALLOC, 3'd7, 32'h0000_0000);
    // Steal wraps from the top processor round to zero
    send_item(CMD_ALLOC, 3'd7, 32'hFFFF_FFFF);
    send_item(CMD_ALLOC, 3'd3, 32'h0000_0000);
    send_item(CMD_FREE,  3'd5, 32'h8000_5000);
    send_item(CMD_FREE,  3'd5, 32'h8000_6000);
    send_item(CMD_ALLOC, 3'd2, 32'h0000_0000);
    // Same page freed onto two lists
    send_item(CMD_FREE,  3'd1, 32'h8000_7000);
    send_item(CMD_FREE,  3'd2, 32'h8000_7000);
    send_item(CMD_ALLOC, 3'd1, 32'h0000_0000);
    send_item(CMD_ALLOC, 3'd1, 32'h0000_0000);
    send_item(CMD_ALLOC, 3'd6, 32'h0000_0000);
    send_item(CMD_ALLOC, 3'd4, 32'h0000_0000);
    send_item(CMD_FREE,  3'd4, 32'h8000_1000);
    send_item(CMD_ALLOC, 3'd4, 32'hFFFF_FFFF);
    drain();
  endtask

  task automatic test_random_default_window();
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    run_random_traffic(450, 64, 55, 2);
    drain();
  endtask

  task automatic test_unaligned_base();
    write_reg(CFG_FIRST_FREE, 32'h0000_0001);
    write_reg(CFG_TOP, 32'h0003_0000);
    send_gaps = 1'b0;
    recv_gaps = 1'b1;
    run_random_traffic(400, 64, 50, 0);
    drain();
  endtask

  task automatic test_full_range();
    write_reg(CFG_FIRST_FREE, 32'h0000_0000);
    write_reg(CFG_TOP, 32'hFFFF_FFFF);
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    run_random_traffic(300, 40, 55, 6);
    drain();
  endtask

  // Listed slots keep their place; addresses follow the new base and wrap
  task automatic test_base_wrap();
    write_reg(CFG_FIRST_FREE, 32'hFFFF_FFFF);
    write_reg(CFG_TOP, 32'h0000_0000);
    send_gaps = 1'b1;
    recv_gaps = 1'b0;
    run_random_traffic(100, 16, 30, 0);
    drain();
    write_reg(CFG_FIRST_FREE, 32'hFFFF_0000);
    write_reg(CFG_TOP, 32'hFFFF_FFFF);
    recv_gaps = 1'b1;
    run_random_traffic(250, 20, 50, 0);
    drain();
  endtask

  task automatic test_backpressure();
    write_reg(CFG_FIRST_FREE, CFG_FIRST_RESET);
    write_reg(CFG_TOP, CFG_TOP_RESET);
    send_gaps = 1'b0;
    recv_gaps = 1'b1;
    recv_hold = 300;
    run_random_traffic(100, 32, 50, 0);
    drain();
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: stall for a drawn number of cycles, take one beat, check it
  initial begin : result_sink
    int unsigned  gap;
    page_result_t exp_r;
    wait (!rst);
    @(negedge clk);
    forever begin
      gap = (recv_gaps ? $urandom_range(0, 9) : 0) + recv_hold;
      recv_hold = 0;
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: page_addr %h status %0d source_cpu %0d",
               page_addr, status, source_cpu);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (page_addr !== exp_r.page_addr) begin
          $error("page_addr: expected %h, got %h", exp_r.page_addr, page_addr);
          fail_count++;
        end
        if (status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, status);
          fail_count++;
        end
        if (source_cpu !== exp_r.source_cpu) begin
          $error("source_cpu: expected %0d, got %0d", exp_r.source_cpu, source_cpu);
          fail_count++;
        end
      end
      @(negedge clk);
    end
  end

  initial begin
    for (int i = 0; i < CPUS; i++) begin
      head_slot[i] = '0;
      head_live[i] = 1'b0;
    end
    for (int i = 0; i < SLOTS; i++) begin
      link_slot[i] = '0;
      link_live[i] = 1'b0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_basics();
    test_random_default_window();
    test_unaligned_base();
    test_full_range();
    test_base_wrap();
    test_backpressure();

    repeat (8) @(posedge clk);
    fail_count += pending_results.size();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
